@@ rtl/akf_pkg.sv @@
// ----------------------------------------------------------------------------
// akf_pkg: shared types, constants and arithmetic helpers
// Q16.16 saturating helpers, register map and sequencer states for the
// two-state angle Kalman filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package akf_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DivSteps  = 48;
  localparam int unsigned CntWidth  = $clog2(DivSteps);

  localparam logic [30:0] RstNoiseAngle = 31'd66;
  localparam logic [30:0] RstNoiseBias  = 31'd197;
  localparam logic [30:0] RstNoiseMeas  = 31'd1966;
  localparam logic [16:0] RstPeriod     = 17'd328;
  localparam logic [31:0] RstAngle      = 32'd0;
  localparam logic [31:0] RstBias       = 32'd0;
  localparam logic [30:0] RstCovDiag    = 31'd65536;
  localparam logic [31:0] RstCovOff     = 32'd0;

  typedef enum logic [2:0] {
    REG_NOISE_ANGLE = 3'd0,
    REG_NOISE_BIAS  = 3'd1,
    REG_NOISE_MEAS  = 3'd2,
    REG_PERIOD      = 3'd3,
    REG_INIT_ANGLE  = 3'd4,
    REG_INIT_BIAS   = 3'd5,
    REG_INIT_DIAG   = 3'd6,
    REG_INIT_OFF    = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MWAIT,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_DIV,
    ST_U0,
    ST_U1,
    ST_U2,
    ST_U3,
    ST_U4,
    ST_U5
  } state_e;

  // Saturate a 33-bit signed sum to 32 bits.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat33({a[31], a} + {b[31], b});
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat33({a[31], a} - {b[31], b});
  endfunction

  // Saturate a 49-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
    if (v > 49'sd2147483647) begin
      return 32'sh7fff_ffff;
    end
    if (v < -49'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Round a full product to Q16.16, ties toward +infinity, then saturate.
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return sat49({t[63], t[63:16]});
  endfunction

endpackage

@@ rtl/akf_stream_if.sv @@
// ----------------------------------------------------------------------------
// akf_in_if / akf_out_if: sample and estimate channels
// Valid/ready channels carrying the filter input sample and its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface akf_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [akf_pkg::DataWidth-1:0]      measured_angle;
  logic signed [akf_pkg::DataWidth-1:0]      gyro_rate;

  modport source (output valid, output measured_angle, output gyro_rate, input ready);
  modport sink   (input valid, input measured_angle, input gyro_rate, output ready);
endinterface

interface akf_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [akf_pkg::DataWidth-1:0]      angle_estimate;
  logic signed [akf_pkg::DataWidth-1:0]      bias_estimate;

  modport source (output valid, output angle_estimate, output bias_estimate, input ready);
  modport sink   (input valid, input angle_estimate, input bias_estimate, output ready);
endinterface

@@ rtl/angle_kalman_filter.sv @@
// ----------------------------------------------------------------------------
// angle_kalman_filter: two-state angle and gyro bias Kalman filter
// Fuses an accelerometer angle with a gyro rate in saturating Q16.16, using
// one shared multiplier and one bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Contents                           Handshake
//   in_i      sink       measured_angle, gyro_rate          valid/ready
//   out_o     source     angle_estimate, bias_estimate      valid/ready
//   APB       slave      eight configuration registers      psel/penable
//
// Each sample runs from the idle state that takes it through ten products in
// the shared multiplier, each with registered operands and product, and two
// gain divisions through the restoring divider, one after the other.
// Reset loads the configuration reset values and the matching filter state.
// The input is ready only while the sequencer is idle; a finished result is
// held in the output register, and a new sample may be taken while it waits.
// The last update step stalls if the previous result has not been transferred.
`timescale 1ns / 1ps

module angle_kalman_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  akf_in_if.sink                              in_i,
  akf_out_if.source                           out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [akf_pkg::AddrWidth-1:0]       paddr,
  input  logic [akf_pkg::DataWidth-1:0]       pwdata,
  output logic [akf_pkg::DataWidth-1:0]       prdata,
  output logic                                pready
);

  // Configuration registers.
  logic [30:0]        pna_q, pnb_q, mn_q, diag_q;
  logic [16:0]        dt_q;
  logic signed [31:0] ia_q, ib_q, off_q;

  // Filter state.
  logic signed [31:0] ang_q, ang_d, bias_q, bias_d;
  logic signed [31:0] c00_q, c00_d, c01_q, c01_d, c10_q, c10_d, c11_q, c11_d;

  // Working registers of one sample.
  logic signed [31:0] meas_q, meas_d;
  logic signed [31:0] s_q, s_d, k0_q, k0_d, k1_q, k1_d, y_q, y_d;
  logic signed [31:0] t00_q, t00_d, t01_q, t01_d;

  // Shared multiplier: operands are registered, then the product.
  logic signed [31:0] ma_q, ma_d, mb_q, mb_d;
  logic signed [63:0] prod_q;
  logic signed [31:0] mr;

  // Bit-serial divider.
  logic [31:0]               rem_q, rem_d, dvs_q, dvs_d;
  logic [47:0]               quo_q, quo_d;
  logic [akf_pkg::CntWidth-1:0] cnt_q, cnt_d;
  logic                      neg_q, neg_d, dz_q, dz_d, dsel_q, dsel_d;
  logic [32:0]               dsh;
  logic [33:0]               dtrial;
  logic [47:0]               dquo;
  logic signed [48:0]        dsigned;
  logic signed [31:0]        dres;

  akf_pkg::state_e    state_q, state_d, ret_q, ret_d;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_ang_q, out_ang_d, out_bias_q, out_bias_d;

  logic               cfg_wr;
  akf_pkg::reg_idx_e  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = akf_pkg::reg_idx_e'(paddr[4:2]);

  always_comb begin
    case (cfg_idx)
      akf_pkg::REG_NOISE_ANGLE: prdata = {1'b0, pna_q};
      akf_pkg::REG_NOISE_BIAS:  prdata = {1'b0, pnb_q};
      akf_pkg::REG_NOISE_MEAS:  prdata = {1'b0, mn_q};
      akf_pkg::REG_PERIOD:      prdata = {15'd0, dt_q};
      akf_pkg::REG_INIT_ANGLE:  prdata = ia_q;
      akf_pkg::REG_INIT_BIAS:   prdata = ib_q;
      akf_pkg::REG_INIT_DIAG:   prdata = {1'b0, diag_q};
      akf_pkg::REG_INIT_OFF:    prdata = off_q;
      default:                  prdata = '0;
    endcase
  end

  assign in_i.ready           = (state_q == akf_pkg::ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.angle_estimate = out_ang_q;
  assign out_o.bias_estimate  = out_bias_q;

  assign mr = akf_pkg::qround(prod_q);

  // One restoring step: shift in the next dividend bit, try to subtract.
  // The signed result is taken from this step's quotient, so the last step
  // delivers the finished gain.
  assign dsh     = {rem_q, quo_q[47]};
  assign dtrial  = {1'b0, dsh} - {2'b00, dvs_q};
  assign dquo    = dtrial[33] ? {quo_q[46:0], 1'b0} : {quo_q[46:0], 1'b1};
  assign dsigned = neg_q ? -$signed({1'b0, dquo}) : $signed({1'b0, dquo});
  assign dres    = dz_q ? 32'sd0 : akf_pkg::sat49(dsigned);

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    ang_d      = ang_q;
    bias_d     = bias_q;
    c00_d      = c00_q;
    c01_d      = c01_q;
    c10_d      = c10_q;
    c11_d      = c11_q;
    meas_d     = meas_q;
    s_d        = s_q;
    k0_d       = k0_q;
    k1_d       = k1_q;
    y_d        = y_q;
    t00_d      = t00_q;
    t01_d      = t01_q;
    ma_d       = ma_q;
    mb_d       = mb_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    dvs_d      = dvs_q;
    cnt_d      = cnt_q;
    neg_d      = neg_q;
    dz_d       = dz_q;
    dsel_d     = dsel_q;
    out_valid_d = out_valid_q;
    out_ang_d  = out_ang_q;
    out_bias_d = out_bias_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      akf_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          meas_d  = in_i.measured_angle;
          // Predict: angle advances by dt times the bias-corrected rate.
          ma_d    = {15'd0, dt_q};
          mb_d    = akf_pkg::qsub(in_i.gyro_rate, bias_q);
          ret_d   = akf_pkg::ST_P0;
          state_d = akf_pkg::ST_MWAIT;
        end
      end
      akf_pkg::ST_MWAIT: begin
        state_d = ret_q;
      end
      akf_pkg::ST_P0: begin
        ang_d   = akf_pkg::qadd(ang_q, mr);
        ma_d    = {15'd0, dt_q};
        mb_d    = c11_q;
        ret_d   = akf_pkg::ST_P1;
        state_d = akf_pkg::ST_MWAIT;
      end
      akf_pkg::ST_P1: begin
        // The product is dt * P11; the off-diagonal terms take it off now.
        c01_d   = akf_pkg::qsub(c01_q, mr);
        c10_d   = akf_pkg::qsub(c10_q, mr);
        ma_d    = {15'd0, dt_q};
        mb_d    = akf_pkg::qadd(akf_pkg::qsub(akf_pkg::qsub(mr, c01_q), c10_q),
                                {1'b0, pna_q});
        ret_d   = akf_pkg::ST_P2;
        state_d = akf_pkg::ST_MWAIT;
      end
      akf_pkg::ST_P2: begin
        c00_d   = akf_pkg::qadd(c00_q, mr);
        ma_d    = {1'b0, pnb_q};
        mb_d    = {15'd0, dt_q};
        ret_d   = akf_pkg::ST_P3;
        state_d = akf_pkg::ST_MWAIT;
      end
      akf_pkg::ST_P3: begin
        c11_d   = akf_pkg::qadd(c11_q, mr);
        // Innovation variance, then the first gain division.
        s_d     = akf_pkg::qadd(c00_q, {1'b0, mn_q});
        neg_d   = c00_q[31] ^ s_d[31];
        dz_d    = (s_d == 32'sd0);
        quo_d   = {(c00_q[31] ? 32'(-c00_q) : 32'(c00_q)), 16'd0};
        dvs_d   = s_d[31] ? 32'(-s_d) : 32'(s_d);
        rem_d   = '0;
        cnt_d   = '0;
        dsel_d  = 1'b0;
        state_d = akf_pkg::ST_DIV;
      end
      akf_pkg::ST_DIV: begin
        if (!dtrial[33]) begin
          rem_d = dtrial[31:0];
        end else begin
          rem_d = dsh[31:0];
        end
        quo_d = dquo;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == akf_pkg::CntWidth'(akf_pkg::DivSteps - 1)) begin
          if (!dsel_q) begin
            k0_d   = dres;
            neg_d  = c10_q[31] ^ s_q[31];
            quo_d  = {(c10_q[31] ? 32'(-c10_q) : 32'(c10_q)), 16'd0};
            rem_d  = '0;
            cnt_d  = '0;
            dsel_d = 1'b1;
          end else begin
            k1_d    = dres;
            y_d     = akf_pkg::qsub(meas_q, ang_q);
            ma_d    = k0_q;
            mb_d    = y_d;
            ret_d   = akf_pkg::ST_U0;
            state_d = akf_pkg::ST_MWAIT;
          end
        end
      end
      akf_pkg::ST_U0: begin
        ang_d   = akf_pkg::qadd(ang_q, mr);
        ma_d    = k1_q;
        mb_d    = y_q;
        ret_d   = akf_pkg::ST_U1;
        state_d = akf_pkg::ST_MWAIT;
      end
      akf_pkg::ST_U1: begin
        bias_d  = akf_pkg::qadd(bias_q, mr);
        // Covariance update reads the predicted P00 and P01.
        t00_d   = c00_q;
        t01_d   = c01_q;
        ma_d    = k0_q;
        mb_d    = c00_q;
        ret_d   = akf_pkg::ST_U2;
        state_d = akf_pkg::ST_MWAIT;
      end
      akf_pkg::ST_U2: begin
        c00_d   = akf_pkg::qsub(c00_q, mr);
        ma_d    = k0_q;
        mb_d    = t01_q;
        ret_d   = akf_pkg::ST_U3;
        state_d = akf_pkg::ST_MWAIT;
      end
      akf_pkg::ST_U3: begin
        c01_d   = akf_pkg::qsub(c01_q, mr);
        ma_d    = k1_q;
        mb_d    = t00_q;
        ret_d   = akf_pkg::ST_U4;
        state_d = akf_pkg::ST_MWAIT;
      end
      akf_pkg::ST_U4: begin
        c10_d   = akf_pkg::qsub(c10_q, mr);
        ma_d    = k1_q;
        mb_d    = t01_q;
        ret_d   = akf_pkg::ST_U5;
        state_d = akf_pkg::ST_MWAIT;
      end
      akf_pkg::ST_U5: begin
        // Wait here until the output register is free.
        if (!out_valid_d) begin
          c11_d       = akf_pkg::qsub(c11_q, mr);
          out_valid_d = 1'b1;
          out_ang_d   = ang_q;
          out_bias_d  = bias_q;
          state_d     = akf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = akf_pkg::ST_IDLE;
      end
    endcase

    // Writes to the initial-value registers also load the matching state.
    if (cfg_wr) begin
      case (cfg_idx)
        akf_pkg::REG_INIT_ANGLE: ang_d = pwdata;
        akf_pkg::REG_INIT_BIAS:  bias_d = pwdata;
        akf_pkg::REG_INIT_DIAG: begin
          c00_d = {1'b0, pwdata[30:0]};
          c11_d = {1'b0, pwdata[30:0]};
        end
        akf_pkg::REG_INIT_OFF: begin
          c01_d = pwdata;
          c10_d = pwdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pna_q  <= akf_pkg::RstNoiseAngle;
      pnb_q  <= akf_pkg::RstNoiseBias;
      mn_q   <= akf_pkg::RstNoiseMeas;
      dt_q   <= akf_pkg::RstPeriod;
      ia_q   <= akf_pkg::RstAngle;
      ib_q   <= akf_pkg::RstBias;
      diag_q <= akf_pkg::RstCovDiag;
      off_q  <= akf_pkg::RstCovOff;
    end else if (cfg_wr) begin
      case (cfg_idx)
        akf_pkg::REG_NOISE_ANGLE: pna_q  <= pwdata[30:0];
        akf_pkg::REG_NOISE_BIAS:  pnb_q  <= pwdata[30:0];
        akf_pkg::REG_NOISE_MEAS:  mn_q   <= pwdata[30:0];
        akf_pkg::REG_PERIOD:      dt_q   <= pwdata[16:0];
        akf_pkg::REG_INIT_ANGLE:  ia_q   <= pwdata;
        akf_pkg::REG_INIT_BIAS:   ib_q   <= pwdata;
        akf_pkg::REG_INIT_DIAG:   diag_q <= pwdata[30:0];
        akf_pkg::REG_INIT_OFF:    off_q  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= akf_pkg::ST_IDLE;
      ret_q       <= akf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      ang_q       <= akf_pkg::RstAngle;
      bias_q      <= akf_pkg::RstBias;
      c00_q       <= {1'b0, akf_pkg::RstCovDiag};
      c11_q       <= {1'b0, akf_pkg::RstCovDiag};
      c01_q       <= akf_pkg::RstCovOff;
      c10_q       <= akf_pkg::RstCovOff;
      cnt_q       <= '0;
      dsel_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      ang_q       <= ang_d;
      bias_q      <= bias_d;
      c00_q       <= c00_d;
      c01_q       <= c01_d;
      c10_q       <= c10_d;
      c11_q       <= c11_d;
      cnt_q       <= cnt_d;
      dsel_q      <= dsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meas_q     <= meas_d;
    s_q        <= s_d;
    k0_q       <= k0_d;
    k1_q       <= k1_d;
    y_q        <= y_d;
    t00_q      <= t00_d;
    t01_q      <= t01_d;
    ma_q       <= ma_d;
    mb_q       <= mb_d;
    prod_q     <= ma_q * mb_q;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dvs_q      <= dvs_d;
    neg_q      <= neg_d;
    dz_q       <= dz_d;
    out_ang_q  <= out_ang_d;
    out_bias_q <= out_bias_d;
  end

endmodule

@@ tb/sv/angle_kalman_filter_tb.sv @@
// ----------------------------------------------------------------------------
// angle_kalman_filter_tb: self-checking bench for the angle Kalman filter
// Drives samples and register writes, predicts every angle and bias estimate
// with a Q16.16 model of the filter and compares each transfer as it arrives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module angle_kalman_filter_tb;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
  } estimate_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [akf_pkg::AddrWidth-1:0] paddr;
  logic [akf_pkg::DataWidth-1:0] pwdata;
  logic [akf_pkg::DataWidth-1:0] prdata;
  logic pready;

  akf_in_if  sample_ch ();
  akf_out_if estimate_ch ();

  angle_kalman_filter uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (sample_ch.sink),
    .out_o   (estimate_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the configuration and filter state.
  logic signed [31:0] q_noise_angle, q_noise_bias, q_noise_meas, q_period;
  logic signed [31:0] q_init_angle, q_init_bias, q_init_diag, q_init_off;
  logic signed [31:0] f_angle, f_bias, f_p00, f_p01, f_p10, f_p11;

  estimate_t expected_estimates[$];
  int        error_count;
  int        send_idle_pct;
  int        recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Limit sized for well over a thousand samples, plus idling on both sides.
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic signed [31:0] clamp64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] wa, wb;
    wa = a;
    wb = b;
    return clamp64(wa + wb);
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] wa, wb;
    wa = a;
    wb = b;
    return clamp64(wa - wb);
  endfunction

  // Product rounded to nearest with ties toward +infinity: floor(p/2^16)
  // after adding half an LSB, done by an arithmetic shift.
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] wa, wb, p;
    wa = a;
    wb = b;
    p = wa * wb + 64'sd32768;
    return clamp64(p >>> 16);
  endfunction

  // Quotient truncated toward zero; a zero divisor yields a zero gain.
  function automatic logic signed [31:0] fx_div(input logic signed [31:0] n,
                                                input logic signed [31:0] d);
    logic signed [63:0] wn, wd;
    if (d == 0) return 32'sd0;
    wn = n;
    wd = d;
    return clamp64((wn * 64'sd65536) / wd);
  endfunction

  function automatic estimate_t filter_sample(input logic signed [31:0] meas,
                                              input logic signed [31:0] rate);
    logic signed [31:0] dtp11, s, k0, k1, y, t00, t01;
    estimate_t r;
    f_angle = fx_add(f_angle, fx_mul(q_period, fx_sub(rate, f_bias)));
    dtp11   = fx_mul(q_period, f_p11);
    f_p00   = fx_add(f_p00, fx_mul(q_period,
                fx_add(fx_sub(fx_sub(dtp11, f_p01), f_p10), q_noise_angle)));
    f_p01   = fx_sub(f_p01, dtp11);
    f_p10   = fx_sub(f_p10, dtp11);
    f_p11   = fx_add(f_p11, fx_mul(q_noise_bias, q_period));
    s  = fx_add(f_p00, q_noise_meas);
    k0 = fx_div(f_p00, s);
    k1 = fx_div(f_p10, s);
    y  = fx_sub(meas, f_angle);
    f_angle = fx_add(f_angle, fx_mul(k0, y));
    f_bias  = fx_add(f_bias, fx_mul(k1, y));
    t00 = f_p00;
    t01 = f_p01;
    f_p00 = fx_sub(f_p00, fx_mul(k0, t00));
    f_p01 = fx_sub(f_p01, fx_mul(k0, t01));
    f_p10 = fx_sub(f_p10, fx_mul(k1, t00));
    f_p11 = fx_sub(f_p11, fx_mul(k1, t01));
    r.angle = f_angle;
    r.bias  = f_bias;
    return r;
  endfunction

  task automatic reset_predictor();
    q_noise_angle = 32'(akf_pkg::RstNoiseAngle);
    q_noise_bias  = 32'(akf_pkg::RstNoiseBias);
    q_noise_meas  = 32'(akf_pkg::RstNoiseMeas);
    q_period      = 32'(akf_pkg::RstPeriod);
    q_init_angle  = akf_pkg::RstAngle;
    q_init_bias   = akf_pkg::RstBias;
    q_init_diag   = 32'(akf_pkg::RstCovDiag);
    q_init_off    = akf_pkg::RstCovOff;
    f_angle = q_init_angle;
    f_bias  = q_init_bias;
    f_p00   = q_init_diag;
    f_p11   = q_init_diag;
    f_p01   = q_init_off;
    f_p10   = q_init_off;
  endtask

  // Mirror a register write in the predictor; the initial registers also
  // reload the matching filter state at once.
  task automatic apply_register(input akf_pkg::reg_idx_e idx, input logic [31:0] value);
    case (idx)
      akf_pkg::REG_NOISE_ANGLE: q_noise_angle = {1'b0, value[30:0]};
      akf_pkg::REG_NOISE_BIAS:  q_noise_bias  = {1'b0, value[30:0]};
      akf_pkg::REG_NOISE_MEAS:  q_noise_meas  = {1'b0, value[30:0]};
      akf_pkg::REG_PERIOD:      q_period      = {15'd0, value[16:0]};
      akf_pkg::REG_INIT_ANGLE: begin
        q_init_angle = value;
        f_angle      = value;
      end
      akf_pkg::REG_INIT_BIAS: begin
        q_init_bias = value;
        f_bias      = value;
      end
      akf_pkg::REG_INIT_DIAG: begin
        q_init_diag = {1'b0, value[30:0]};
        f_p00       = q_init_diag;
        f_p11       = q_init_diag;
      end
      akf_pkg::REG_INIT_OFF: begin
        q_init_off = value;
        f_p01      = value;
        f_p10      = value;
      end
      default: ;
    endcase
  endtask

  // Setup and access phases, driven at the falling edge.
  task automatic write_register(input akf_pkg::reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= akf_pkg::AddrWidth'(4 * int'(idx));
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_register(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Waits until every expected estimate has been transferred, then lets the
  // sequencer settle before any register is touched.
  task automatic drain_results();
    while (expected_estimates.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // Sends one sample; with keep_valid set, valid stays high for a back-to-back transfer.
  task automatic send_sample(input logic signed [31:0] meas,
                             input logic signed [31:0] rate,
                             input bit keep_valid);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.measured_angle <= meas;
    sample_ch.gyro_rate      <= rate;
    do @(posedge clk_i); while (!sample_ch.ready);
    expected_estimates.push_back(filter_sample(meas, rate));
    if (!keep_valid) begin
      @(negedge clk_i);
      sample_ch.valid <= 1'b0;
    end
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  // Checker: compares each transfer with the oldest expected estimate.
  always @(posedge clk_i) begin
    estimate_t want;
    if (rst_ni && estimate_ch.valid && estimate_ch.ready) begin
      if (expected_estimates.size() == 0) begin
        $display("%0t: unexpected estimate angle=%h bias=%h", $realtime,
                 estimate_ch.angle_estimate, estimate_ch.bias_estimate);
        error_count++;
      end else begin
        want = expected_estimates.pop_front();
        if (estimate_ch.angle_estimate !== want.angle) begin
          $display("%0t: angle_estimate expected %h actual %h", $realtime,
                   want.angle, estimate_ch.angle_estimate);
          error_count++;
        end
        if (estimate_ch.bias_estimate !== want.bias) begin
          $display("%0t: bias_estimate expected %h actual %h", $realtime,
                   want.bias, estimate_ch.bias_estimate);
          error_count++;
        end
      end
    end
  end

  // Receiver stalls at random, at the rate recv_idle_pct sets.
  always @(negedge clk_i) begin
    estimate_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Directed samples at the field extremes and the saturation corners.
  task automatic test_field_extremes();
    send_sample(32'sh0000_0000, 32'sh0000_0000, 1'b0);
    send_sample(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_sample(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_sample(32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
    send_sample(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    send_sample(32'sh0001_0000, 32'shffff_0000, 1'b0);
    send_sample(32'shffff_ffff, 32'sh0000_0001, 1'b0);
    send_sample(32'sh5555_5555, 32'shaaaa_aaaa, 1'b0);
  endtask

  // Zero and negative innovation variance, and register extremes.
  task automatic test_gain_corners();
    drain_results();
    write_register(akf_pkg::REG_NOISE_MEAS, 32'd0);
    write_register(akf_pkg::REG_INIT_DIAG, 32'd0);
    write_register(akf_pkg::REG_PERIOD, 32'd0);
    write_register(akf_pkg::REG_NOISE_ANGLE, 32'd0);
    send_sample(32'sh0002_0000, 32'sh0000_1000, 1'b0);
    drain_results();
    write_register(akf_pkg::REG_INIT_DIAG, 32'h7fff_ffff);
    write_register(akf_pkg::REG_NOISE_MEAS, 32'h7fff_ffff);
    write_register(akf_pkg::REG_PERIOD, 32'h0001_ffff);
    write_register(akf_pkg::REG_NOISE_ANGLE, 32'h7fff_ffff);
    write_register(akf_pkg::REG_NOISE_BIAS, 32'h7fff_ffff);
    write_register(akf_pkg::REG_INIT_OFF, 32'h8000_0000);
    write_register(akf_pkg::REG_INIT_ANGLE, 32'h7fff_ffff);
    write_register(akf_pkg::REG_INIT_BIAS, 32'h8000_0000);
    send_sample(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    send_sample(32'sh1234_5678, 32'sh0000_0000, 1'b0);
    drain_results();
    // Negative covariance drives the innovation variance below zero.
    write_register(akf_pkg::REG_PERIOD, 32'h0001_0000);
    write_register(akf_pkg::REG_NOISE_MEAS, 32'd1);
    write_register(akf_pkg::REG_NOISE_BIAS, 32'd0);
    write_register(akf_pkg::REG_INIT_OFF, 32'h7fff_ffff);
    write_register(akf_pkg::REG_INIT_DIAG, 32'h0000_0100);
    write_register(akf_pkg::REG_INIT_ANGLE, 32'h8000_0000);
    write_register(akf_pkg::REG_INIT_BIAS, 32'h7fff_ffff);
    send_sample(32'sh0000_4000, 32'shfff0_0000, 1'b0);
    send_sample(32'sh0000_0000, 32'sh0000_0000, 1'b0);
    drain_results();
  endtask

  // Random phases, each with its own register setting; the first keeps
  // both sides busy with no idling.
  task automatic test_random_phases();
    int n;
    for (int ph = 0; ph < 10; ph++) begin
      drain_results();
      send_idle_pct = (ph == 0) ? 0 : 30;
      recv_idle_pct = (ph == 0) ? 0 : 30;
      if (ph == 0) begin
        write_register(akf_pkg::REG_NOISE_ANGLE, 32'd66);
        write_register(akf_pkg::REG_NOISE_BIAS, 32'd197);
        write_register(akf_pkg::REG_NOISE_MEAS, 32'd1966);
        write_register(akf_pkg::REG_PERIOD, 32'd328);
        write_register(akf_pkg::REG_INIT_OFF, 32'd0);
        write_register(akf_pkg::REG_INIT_DIAG, 32'd65536);
        write_register(akf_pkg::REG_INIT_ANGLE, 32'd0);
        write_register(akf_pkg::REG_INIT_BIAS, 32'd0);
      end else if (ph < 7) begin
        write_register(akf_pkg::REG_NOISE_ANGLE, $urandom_range(20000));
        write_register(akf_pkg::REG_NOISE_BIAS, $urandom_range(20000));
        write_register(akf_pkg::REG_NOISE_MEAS, $urandom_range(200000));
        write_register(akf_pkg::REG_PERIOD, $urandom_range(65536));
        write_register(akf_pkg::REG_INIT_DIAG, $urandom_range(1 << 20));
        write_register(akf_pkg::REG_INIT_OFF,
                       32'($signed($urandom_range(8192)) - 4096));
        write_register(akf_pkg::REG_INIT_ANGLE,
                       32'($signed($urandom_range(1 << 22)) - (1 << 21)));
        write_register(akf_pkg::REG_INIT_BIAS,
                       32'($signed($urandom_range(1 << 18)) - (1 << 17)));
      end else begin
        write_register(akf_pkg::REG_NOISE_ANGLE, $urandom);
        write_register(akf_pkg::REG_NOISE_BIAS, $urandom);
        write_register(akf_pkg::REG_NOISE_MEAS, $urandom);
        write_register(akf_pkg::REG_PERIOD, $urandom);
        write_register(akf_pkg::REG_INIT_DIAG, $urandom);
        write_register(akf_pkg::REG_INIT_OFF, $urandom);
        write_register(akf_pkg::REG_INIT_ANGLE, $urandom);
        write_register(akf_pkg::REG_INIT_BIAS, $urandom);
      end
      n = 100 + $urandom_range(10);
      for (int i = 0; i < n; i++) begin
        if (ph < 7 && $urandom_range(9) != 0)
          // Realistic tilt angles and rates that keep the filter tracking.
          send_sample(32'($signed($urandom_range(1 << 22)) - (1 << 21)),
                      32'($signed($urandom_range(1 << 20)) - (1 << 19)),
                      $urandom_range(1));
        else
          send_sample(random_word(), random_word(), $urandom_range(1));
        // Hold off until the pipeline is empty now and then.
        if (i == n / 2) begin
          @(negedge clk_i);
          sample_ch.valid <= 1'b0;
          while (expected_estimates.size() != 0) @(posedge clk_i);
        end
      end
      @(negedge clk_i);
      sample_ch.valid <= 1'b0;
    end
  endtask

  initial begin
    error_count   = 0;
    send_idle_pct = 30;
    recv_idle_pct = 30;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    sample_ch.valid          = 1'b0;
    sample_ch.measured_angle = '0;
    sample_ch.gyro_rate      = '0;
    estimate_ch.ready        = 1'b0;
    reset_predictor();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_field_extremes();
    test_gain_corners();
    test_random_phases();

    drain_results();
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
